>>> design/svafp_pkg.sv
// Shared types and constants of the signed value ASCII frame packer.
package svafp_pkg;

	localparam int unsigned MAG_W = 10;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [MAG_W-1:0] SAT_LIMIT_RESET = 10'd600;
	localparam logic [MAG_W-1:0] SAT_LIMIT_MAX = 10'd999;

	// Register index of the saturation limit
	localparam logic REG_SAT_LIMIT = 1'b0;

	localparam logic [7:0] CHAR_LEAD = 8'h64;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE = 8'h31;

	// One classified value waiting for serialization
	typedef struct packed {
		logic neg;
		logic first;
		logic last;
		logic [DIGIT_W-1:0] d2;
		logic [DIGIT_W-1:0] d1;
		logic [DIGIT_W-1:0] d0;
	} entry_t;

	// Queue head as seen by the serializer
	typedef struct packed {
		logic empty;
		entry_t head;
	} q_status_t;

	// Byte slot within the bytes of one value
	typedef enum logic [2:0] {
		SLOT_LEAD,
		SLOT_SIGN,
		SLOT_D2,
		SLOT_D1,
		SLOT_D0,
		SLOT_SEP,
		SLOT_CR
	} slot_t;

endpackage

>>> design/svafp_front.sv
// Front end: accepts values, saturates them and splits the magnitude into decimal digits.
module svafp_front import svafp_pkg::*; #(
	parameter int unsigned VALUES_PER_FRAME = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] value_in,
	input  logic [MAG_W-1:0]   sat_limit,
	input  logic               q_full,
	output logic               q_push,
	output entry_t             q_data
);

	localparam int unsigned FRAME_LEN = (VALUES_PER_FRAME < 2) ? 2 :
		((VALUES_PER_FRAME > 7) ? 7 : VALUES_PER_FRAME);
	localparam logic [2:0] LAST_POS = 3'(FRAME_LEN - 1);

	logic [2:0] pos_q;

	logic v_s1, v_s2, v_s3;
	logic neg_s1, first_s1, last_s1;
	logic [MAG_W-1:0] mag_s1;
	logic neg_s2, first_s2, last_s2;
	logic [DIGIT_W-1:0] d2_s2;
	logic [6:0] rem_s2;
	entry_t ent_s3;

	logic adv3, ld3, adv2, ld2, adv1, ld1, accept;
	logic [31:0] raw, mag_in;
	logic neg_in;
	logic [MAG_W-1:0] lim_eff, mag_sat;
	logic [15:0] prod_h;
	logic [DIGIT_W-1:0] hund;
	logic [MAG_W-1:0] rem_h;
	logic [14:0] prod_t;
	logic [DIGIT_W-1:0] tens;
	logic [6:0] ones_w;

	// Stall chain from the queue back to the input
	always_comb begin
		adv3 = v_s3 & ~q_full;
		ld3 = ~v_s3 | adv3;
		adv2 = v_s2 & ld3;
		ld2 = ~v_s2 | adv2;
		adv1 = v_s1 & ld2;
		ld1 = ~v_s1 | adv1;
		full = ~ld1;
		accept = push & ~full;
		q_push = adv3;
		q_data = ent_s3;
	end

	// Take magnitude and saturate against the limit
	always_comb begin
		raw = value_in;
		neg_in = raw[31];
		mag_in = neg_in ? (32'd0 - raw) : raw;
		lim_eff = (sat_limit > SAT_LIMIT_MAX) ? SAT_LIMIT_MAX : sat_limit;
		mag_sat = (mag_in > {22'd0, lim_eff}) ? lim_eff : mag_in[MAG_W-1:0];
	end

	// Hundreds digit by reciprocal multiply, valid below 1000
	always_comb begin
		prod_h = 16'(mag_s1) * 16'd41;
		hund = prod_h[15:12];
		rem_h = mag_s1 - 10'(hund) * 10'd100;
	end

	// Tens and ones digits by reciprocal multiply
	always_comb begin
		prod_t = 15'(rem_s2) * 15'd205;
		tens = prod_t[14:11];
		ones_w = rem_s2 - 7'(tens) * 7'd10;
	end

	// Track position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
		end else if (accept) begin
			pos_q <= (pos_q == LAST_POS) ? 3'd0 : pos_q + 3'd1;
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= accept;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (ld1 && accept) begin
			neg_s1 <= neg_in;
			mag_s1 <= mag_sat;
			first_s1 <= (pos_q == 3'd0);
			last_s1 <= (pos_q == LAST_POS);
		end
		if (adv1) begin
			neg_s2 <= neg_s1;
			first_s2 <= first_s1;
			last_s2 <= last_s1;
			d2_s2 <= hund;
			rem_s2 <= rem_h[6:0];
		end
		if (adv2) begin
			ent_s3.neg <= neg_s2;
			ent_s3.first <= first_s2;
			ent_s3.last <= last_s2;
			ent_s3.d2 <= d2_s2;
			ent_s3.d1 <= tens;
			ent_s3.d0 <= ones_w[DIGIT_W-1:0];
		end
	end

endmodule

>>> design/svafp_queue.sv
// Two-entry queue between the front end and the serializer.
module svafp_queue import svafp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  entry_t    wr_data,
	output logic      q_full,
	input  logic      rd_en,
	output q_status_t status
);

	entry_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	always_comb begin
		q_full = (count_q == 2'd2);
		status.empty = (count_q == 2'd0);
		status.head = mem_q[rd_ptr_q];
	end

	// Store requests
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/svafp_back.sv
// Serializer: frame bytes of each queued value, one per cycle if not stalled.
module svafp_back import svafp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t status,
	output logic      rd_en,
	output logic      empty,
	input  logic      pop,
	output logic [7:0] out_byte,
	output logic      last_of_run,
	output logic      end_of_frame
);

	slot_t slot_q, slot_d, cur_slot;
	logic out_valid_q;
	logic [7:0] byte_q;
	logic last_q, eof_q;

	logic emit, done;
	logic [7:0] byte_d;
	entry_t head;

	assign empty = ~out_valid_q;
	assign out_byte = byte_q;
	assign last_of_run = last_q;
	assign end_of_frame = eof_q;

	// Pick the byte for the current slot
	always_comb begin
		head = status.head;
		emit = ~status.empty & (~out_valid_q | pop);
		cur_slot = (slot_q == SLOT_LEAD && !head.first) ? SLOT_SIGN : slot_q;
		done = 1'b0;
		slot_d = slot_q;
		case (cur_slot)
			SLOT_LEAD: begin
				byte_d = CHAR_LEAD;
				slot_d = SLOT_SIGN;
			end
			SLOT_SIGN: begin
				byte_d = head.neg ? CHAR_ONE : CHAR_ZERO;
				slot_d = SLOT_D2;
			end
			SLOT_D2: begin
				byte_d = CHAR_ZERO + 8'(head.d2);
				slot_d = SLOT_D1;
			end
			SLOT_D1: begin
				byte_d = CHAR_ZERO + 8'(head.d1);
				slot_d = SLOT_D0;
			end
			SLOT_D0: begin
				byte_d = CHAR_ZERO + 8'(head.d0);
				slot_d = SLOT_SEP;
			end
			SLOT_SEP: begin
				byte_d = head.last ? CHAR_LF : CHAR_COLON;
				done = ~head.last;
				slot_d = head.last ? SLOT_CR : SLOT_LEAD;
			end
			SLOT_CR: begin
				byte_d = CHAR_CR;
				done = 1'b1;
				slot_d = SLOT_LEAD;
			end
			default: begin
				byte_d = CHAR_CR;
				done = 1'b1;
				slot_d = SLOT_LEAD;
			end
		endcase
		rd_en = emit & done;
	end

	// Slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_LEAD;
		end else if (emit) begin
			slot_q <= slot_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_d;
			last_q <= done;
			eof_q <= done & head.last;
		end
	end

`ifndef SYNTHESIS
	a_eof_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eof_q |-> last_q && byte_q == CHAR_CR)
		else $error("end of frame on a byte other than the closing CR");

	a_cr_slot_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q == SLOT_CR |-> !status.empty && status.head.last)
		else $error("CR slot reached without a last value at the head");

	a_pop_entry_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !status.empty)
		else $error("queue entry released while queue is empty");

	a_slot_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> slot_q == SLOT_LEAD)
		else $error("slot not restarted after a value finished");
`endif

endmodule

>>> design/signed_value_ascii_frame_packer.sv
// Signed value ASCII frame packer: values go in through push/full, frame bytes come out
// through empty/pop, one byte per clock at best. A value takes five output bytes ('d' is
// added on the first value of a frame, LF and CR replace ':' on the last), so the output
// byte rate of the serializer limits the value rate; a value passes through the front-end
// stages s1, s2 and s3, the queue and the output register before it reaches the output.
// The saturation limit is written at APB addresses 0 to 3 (paddr[2] low) and reads back
// from every address as its low ten bits; limits above 999 act as 999.
module signed_value_ascii_frame_packer import svafp_pkg::*; #(
	parameter int unsigned VALUES_PER_FRAME = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] value_in,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               last_of_run,
	output logic               end_of_frame
);

	logic [MAG_W-1:0] sat_limit_q;
	logic cfg_wr;
	logic q_full, q_push, q_pop;
	entry_t q_data;
	q_status_t q_status;

	assign pready = 1'b1;
	assign prdata = {22'd0, sat_limit_q};
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SAT_LIMIT);

	// Saturation limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_limit_q <= SAT_LIMIT_RESET;
		end else if (cfg_wr) begin
			sat_limit_q <= pwdata[MAG_W-1:0];
		end
	end

	svafp_front #(
		.VALUES_PER_FRAME(VALUES_PER_FRAME)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value_in(value_in),
		.sat_limit(sat_limit_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_data)
	);

	svafp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_push),
		.wr_data(q_data),
		.q_full(q_full),
		.rd_en(q_pop),
		.status(q_status)
	);

	svafp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.status(q_status),
		.rd_en(q_pop),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.end_of_frame(end_of_frame)
	);

endmodule
